// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by bilf_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check under reset: property is off while rst_n is low.
`define BILF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bilf check failed");

// Check that also runs during reset.
`define BILF_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bilf check failed during reset");

`endif

// ===== hw/rtl/bilf_pkg.sv =====
// ----------------------------------------------------------------------------
// bilf_pkg
// Constants, types and helper functions of the binary 3x3 lookup filter.
// ----------------------------------------------------------------------------
package bilf_pkg;

  // Frame geometry
  localparam int WIDTH  = 256;
  localparam int HEIGHT = 256;
  localparam int COL_W  = $clog2(WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT + 1);
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LIMIT  = ROW_W'(HEIGHT);

  // Rule table: 512 entries held in 8 words of 64 bits
  localparam int RULE_ENTRIES = 512;
  localparam int RULE_W       = 64;
  localparam int RULE_WORDS   = RULE_ENTRIES / RULE_W;
  localparam int IDX_W        = $clog2(RULE_ENTRIES);
  localparam int RULE_BIT_W   = $clog2(RULE_W);
  localparam int CFG_IDX_W    = $clog2(RULE_WORDS);

  // Result fields
  localparam int POS_W   = 8;
  localparam int LIT_W   = 17;
  localparam logic [LIT_W-1:0] LIT_MAX = {LIT_W{1'b1}};

  // Stream packing
  localparam int IN_TDATA_W  = 8;
  localparam int RES_DATA_W  = 1 + POS_W + POS_W + LIT_W;
  localparam int OUT_TDATA_W = ((RES_DATA_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RES_DATA_W;

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  // Input item kinds
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } bilf_cmd_t;

  typedef struct packed {
    logic                pixel_out;
    logic [POS_W-1:0]    out_column;
    logic [POS_W-1:0]    out_row;
    logic [LIT_W-1:0]    lit_so_far;
    logic                frame_last;
  } bilf_res_t;

  // Kernel to queue control: results pushed this cycle and room wanted
  typedef struct packed {
    logic       need_two;
    logic [1:0] push;
  } bilf_push_t;

  // Neighbourhood index, top-left in the MSB
  function automatic logic [IDX_W-1:0] make_index(logic [2:0] lft, logic [2:0] cen,
                                                  logic [2:0] rgt);
    return {lft[2], cen[2], rgt[2], lft[1], cen[1], rgt[1], lft[0], cen[0], rgt[0]};
  endfunction

  function automatic logic [LIT_W-1:0] sat_inc(logic [LIT_W-1:0] val);
    return (val == LIT_MAX) ? val : val + LIT_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] to_byte(logic [31:0] val);
    return val[POS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bilf_line_buf.sv =====
// ----------------------------------------------------------------------------
// bilf_line_buf
// Two row buffers in one memory: bit 1 is the older row, bit 0 the row above.
// ----------------------------------------------------------------------------
module bilf_line_buf (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [bilf_pkg::COL_W-1:0] wr_addr,
  input  logic [1:0]                wr_data,
  input  logic [bilf_pkg::COL_W-1:0] rd_addr,
  output logic [1:0]                rd_data
);

  logic [1:0] mem [bilf_pkg::WIDTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/bilf_kernel.sv =====
// ----------------------------------------------------------------------------
// bilf_kernel
// Window, position counters, rule table and per-item result generation.
// ----------------------------------------------------------------------------
module bilf_kernel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bilf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bilf_pkg::RULE_W-1:0]    cfg_data,
  input  logic                          in_acc,
  input  bilf_pkg::bilf_cmd_t           cmd,
  input  logic                          px,
  output bilf_pkg::bilf_push_t          push,
  output bilf_pkg::bilf_res_t           res_a,
  output bilf_pkg::bilf_res_t           res_b
);

  logic [bilf_pkg::RULE_W-1:0]  rule_r [bilf_pkg::RULE_WORDS];
  logic [bilf_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [bilf_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [8:0]                   win_r, win_nxt;
  logic [bilf_pkg::LIT_W-1:0]   lit_r, lit_nxt;

  logic [1:0]                   lb_q;
  logic                         lb_we;
  logic                         item_ok, take, is_drain;
  logic                         t_bit, m_bit, b_bit;
  logic [8:0]                   win_new;
  logic                         row_live, emit_a, emit_b;
  logic [2:0]                   lft_a, cen_a;
  logic [bilf_pkg::IDX_W-1:0]   idx_a, idx_b;
  logic                         bit_a, bit_b;
  logic [bilf_pkg::LIT_W-1:0]   lit_a, lit_b;

  bilf_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (lb_we),
    .wr_addr (col_r),
    .wr_data ({m_bit, px}),
    .rd_addr (col_nxt),
    .rd_data (lb_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bilf_pkg::RULE_WORDS; i++) begin
        rule_r[i] <= '0;
      end
    end else if (cfg_we) begin
      rule_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    is_drain = (cmd == bilf_pkg::CMD_DRAIN);
    // drain ticks only count once every row is in; pixels only before that
    item_ok  = is_drain ? (row_r >= bilf_pkg::ROW_LIMIT) : (row_r < bilf_pkg::ROW_LIMIT);
    take     = in_acc & item_ok;

    m_bit   = lb_q[0];
    t_bit   = (row_r == bilf_pkg::ROW_W'(1)) ? m_bit : lb_q[1];
    // last row is its own lower neighbor while draining
    b_bit   = is_drain ? m_bit : px;
    win_new = {win_r[5:0], t_bit, m_bit, b_bit};

    row_live = (row_r != '0);
    emit_a   = row_live && (col_r != '0);
    emit_b   = row_live && (col_r == bilf_pkg::LAST_COL);

    cen_a = win_new[5:3];
    lft_a = (col_r == bilf_pkg::COL_W'(1)) ? cen_a : win_new[8:6];
    idx_a = bilf_pkg::make_index(lft_a, cen_a, win_new[2:0]);
    idx_b = bilf_pkg::make_index(win_new[5:3], win_new[2:0], win_new[2:0]);
    bit_a = rule_r[idx_a[bilf_pkg::IDX_W-1:bilf_pkg::RULE_BIT_W]]
                  [idx_a[bilf_pkg::RULE_BIT_W-1:0]];
    bit_b = rule_r[idx_b[bilf_pkg::IDX_W-1:bilf_pkg::RULE_BIT_W]]
                  [idx_b[bilf_pkg::RULE_BIT_W-1:0]];

    lit_a = (emit_a && bit_a) ? bilf_pkg::sat_inc(lit_r) : lit_r;
    lit_b = (emit_b && bit_b) ? bilf_pkg::sat_inc(lit_a) : lit_a;

    res_a.pixel_out  = bit_a;
    res_a.out_column = bilf_pkg::to_byte(32'(col_r - bilf_pkg::COL_W'(1)));
    res_a.out_row    = bilf_pkg::to_byte(32'(row_r - bilf_pkg::ROW_W'(1)));
    res_a.lit_so_far = lit_a;
    res_a.frame_last = 1'b0;

    res_b.pixel_out  = bit_b;
    res_b.out_column = bilf_pkg::to_byte(32'(col_r));
    res_b.out_row    = bilf_pkg::to_byte(32'(row_r - bilf_pkg::ROW_W'(1)));
    res_b.lit_so_far = lit_b;
    res_b.frame_last = is_drain;

    push.need_two = (col_r == bilf_pkg::LAST_COL);
    push.push     = take ? {emit_b, emit_a} : 2'b00;

    lb_we   = take & ~is_drain;
    col_nxt = col_r;
    row_nxt = row_r;
    win_nxt = win_r;
    lit_nxt = lit_r;
    if (take) begin
      win_nxt = win_new;
      lit_nxt = lit_b;
      if (col_r == bilf_pkg::LAST_COL) begin
        col_nxt = '0;
        if (is_drain) begin
          // frame done: start the next one clean
          row_nxt = '0;
          win_nxt = '0;
          lit_nxt = '0;
        end else begin
          row_nxt = row_r + bilf_pkg::ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + bilf_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
      lit_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      win_r <= win_nxt;
      lit_r <= lit_nxt;
    end
  end

endmodule

// ===== hw/rtl/bilf_out_queue.sv =====
// ----------------------------------------------------------------------------
// bilf_out_queue
// Small result queue: up to two results in a cycle, one out on out_ready.
// ----------------------------------------------------------------------------
module bilf_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bilf_pkg::bilf_push_t push,
  input  bilf_pkg::bilf_res_t  res_a,
  input  bilf_pkg::bilf_res_t  res_b,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bilf_pkg::bilf_res_t  out_res
);

  bilf_pkg::bilf_res_t        q_r [bilf_pkg::Q_DEPTH];
  logic [bilf_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [bilf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pop;
  logic [bilf_pkg::CNT_W:0]   need;

  always_comb begin
    // room from cnt_r and need_two only, so ready never waits on out_ready
    need      = push.need_two ? (bilf_pkg::CNT_W+1)'(2) : (bilf_pkg::CNT_W+1)'(1);
    room      = ({1'b0, cnt_r} + need) <= (bilf_pkg::CNT_W+1)'(bilf_pkg::Q_DEPTH);
    out_valid = (cnt_r != '0);
    out_res   = q_r[rd_ptr_r];
    pop       = out_valid & out_ready;

    wr_ptr_nxt = wr_ptr_r + bilf_pkg::PTR_W'(push.push[0]) + bilf_pkg::PTR_W'(push.push[1]);
    rd_ptr_nxt = rd_ptr_r + bilf_pkg::PTR_W'(pop);
    cnt_nxt    = cnt_r + bilf_pkg::CNT_W'(push.push[0]) + bilf_pkg::CNT_W'(push.push[1])
               - bilf_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push[0]) begin
      q_r[wr_ptr_r] <= res_a;
    end
    if (push.push[1]) begin
      q_r[wr_ptr_r + bilf_pkg::PTR_W'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/binary_image_3x3_lut_filter_core.sv =====
// Results are queued as their items are accepted and offered in order. Throughput:
// one item per cycle while the queue has room; column 0 yields no result and the last
// column two, so each row after the first gives WIDTH results and a one-per-cycle sink
// never stalls the input; the four-entry queue absorbs the last column's extra result.
// Reset (rst_n low, synchronous): counters, window, lit count, rule table and
// result queue clear; line buffer contents are left as they are.
// ----------------------------------------------------------------------------
// binary_image_3x3_lut_filter_core
// Streaming 3x3 binary filter: line buffers, window and 512-entry rule table.
// ----------------------------------------------------------------------------
module binary_image_3x3_lut_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [bilf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bilf_pkg::RULE_W-1:0]       cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bilf_pkg::IN_TDATA_W-1:0]   in_tdata,   // [0] pixel_in, rest zero
  input  logic                              in_tuser,   // [0] command
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] pixel_out, [8:1] out_column, [16:9] out_row, [33:17] lit_so_far, rest zero
  output logic [bilf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast   // frame_last
);

  bilf_pkg::bilf_push_t push;
  bilf_pkg::bilf_res_t  res_a, res_b, out_res;
  bilf_pkg::bilf_cmd_t  cmd;
  logic                 in_acc;

  assign cmd    = bilf_pkg::bilf_cmd_t'(in_tuser);
  assign in_acc = in_tvalid & in_tready;

  bilf_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_acc    (in_acc),
    .cmd       (cmd),
    .px        (in_tdata[0]),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b)
  );

  bilf_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{bilf_pkg::OUT_PAD_W{1'b0}}, out_res.lit_so_far, out_res.out_row,
                      out_res.out_column, out_res.pixel_out};
  assign out_tlast = out_res.frame_last;

endmodule

// ===== hw/rtl/bilf_checker.sv =====
// ----------------------------------------------------------------------------
// bilf_checker
// Port-level checks on the filter's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bilf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  logic [bilf_pkg::POS_W-1:0] last_col_byte;

  assign last_col_byte = bilf_pkg::to_byte(32'(bilf_pkg::LAST_COL));

  // result queue empties on reset
  `BILF_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_tvalid)

  // stalled result holds
  `BILF_ASSERT(a_stall_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // frame end only on the last column
  `BILF_ASSERT(a_last_column, clk, rst_n,
    out_tvalid && out_tlast |-> out_tdata[8:1] == last_col_byte)

  // a lit pixel is always counted
  `BILF_ASSERT(a_lit_counted, clk, rst_n,
    out_tvalid && out_tdata[0] |-> out_tdata[33:17] != '0)

endmodule

bind binary_image_3x3_lut_filter_core bilf_checker u_bilf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
